[src/fbpa_pkg.sv]
// Shared constants, codes and payload types of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package fbpa_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 17;
	localparam int REQ_W      = 24;
	localparam int CFG_W      = 32;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_DISABLED     = 3'd1,
		ST_TOO_LARGE    = 3'd2,
		ST_POOL_EMPTY   = 3'd3,
		ST_MISALIGNED   = 3'd4,
		ST_OUT_OF_RANGE = 3'd5,
		ST_RING_FULL    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		REG_BASE_ADDRESS = 2'd0,
		REG_BLOCK_SIZE   = 2'd1,
		REG_BLOCK_COUNT  = 2'd2,
		REG_POOL_ENABLED = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_ALLOCATE = 1'b0,
		OP_FREE     = 1'b1
	} op_t;

	typedef struct packed {
		logic              operation;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] free_address;
	} request_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] block_address;
		logic [IDX_W-1:0]  slot_idx;
		logic [CNT_W-1:0]  free_left;
	} response_t;

	typedef struct packed {
		logic [ADDR_W-1:0] quotient;
		logic [SIZE_W-1:0] remainder;
	} div_result_t;

endpackage
`default_nettype wire

[src/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: registers, ring and sequencer.
//
// Usage: a request beat is taken at a clock edge where start is high and busy
// is low. Each request gives exactly one response beat on result, marked by a
// one-cycle done strobe; the receiver cannot stall, so results are never held.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, and the block itself does not enforce it. Index
// 0 base address, 1 block size, 2 block count (refills the free ring in
// identity order), 3 pool enable. From the accepting edge to done:
//   rejected requests (disabled, too large, empty): the next cycle;
//   allocate: ring read, index multiply and base add states in turn;
//   free: the 32-step divider turns the address offset into an index and
//   a remainder, and the result is registered.
// busy is low again in the done cycle, so the next item can be taken at the
// edge that ends it; rejects leave busy low and can be taken every cycle.
// The ring sits in a 256 x 8 RAM with one valid flop per entry; an entry not
// written since reset or the last block count write reads as its own index.
// Reset returns all registers to their defaults: pool disabled, block size
// 64, block count 256, all blocks free. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_pool_allocator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire fbpa_pkg::request_t          request,
	output logic                             done,
	output fbpa_pkg::response_t              result,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [fbpa_pkg::CFG_W-1:0]  cfg_data
);
	import fbpa_pkg::*;

	localparam int PROD_W = IDX_W + SIZE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_ADD,
		S_DIV
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  count_q;
	logic              enable_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  free_q;
	logic [MAX_BLOCKS-1:0] valid_q;
	logic              done_q;
	response_t         result_q;

	logic [IDX_W-1:0]  idx_q;
	logic [PROD_W-1:0] prod_q;
	logic              vld_rd_q;

	logic              accept;
	logic [CNT_W-1:0]  n_eff;
	logic [SIZE_W-1:0] bs_eff;
	logic              too_large;
	logic [ADDR_W-1:0] offset;
	logic [CNT_W:0]    pos_sum;
	logic [CNT_W:0]    pos_wrap;
	logic [IDX_W-1:0]  pos;
	logic [CNT_W-1:0]  head_inc;
	logic [IDX_W-1:0]  head_next;
	logic [IDX_W-1:0]  ring_rdata;
	logic [IDX_W-1:0]  rd_idx;
	logic              div_start;
	logic              div_done;
	div_result_t       div_res;
	logic              misaligned;
	logic              out_of_range;
	logic              ring_full;
	logic              ring_we;
	reg_idx_t          cfg_reg;

	assign cfg_reg = reg_idx_t'(cfg_index);
	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;

	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_BLOCKS)) begin
			n_eff = CNT_W'(MAX_BLOCKS);
		end else begin
			n_eff = count_q;
		end
	end

	assign bs_eff    = (size_q == '0) ? SIZE_W'(1) : size_q;
	assign too_large = (request.request_size > REQ_W'(bs_eff));
	assign offset    = request.free_address - base_q;

	// Head is below the count and the fill count at most the count, so one subtract wraps the tail.
	assign pos_sum  = {1'b0, CNT_W'(head_q)} + {1'b0, free_q};
	assign pos_wrap = (pos_sum >= {1'b0, n_eff}) ? (pos_sum - {1'b0, n_eff}) : pos_sum;
	assign pos      = pos_wrap[IDX_W-1:0];

	assign head_inc  = CNT_W'(head_q) + CNT_W'(1);
	assign head_next = (head_inc >= n_eff) ? '0 : head_inc[IDX_W-1:0];

	assign rd_idx = vld_rd_q ? ring_rdata : head_q;

	assign div_start    = accept && enable_q && (request.operation == OP_FREE);
	assign misaligned   = (div_res.remainder != '0);
	assign out_of_range = (div_res.quotient >= ADDR_W'(n_eff));
	assign ring_full    = (free_q >= n_eff);
	assign ring_we      = (state_q == S_DIV) && div_done && !misaligned
	                      && !out_of_range && !ring_full;

	fbpa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_BLOCKS)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(pos),
		.wdata(div_res.quotient[IDX_W-1:0]),
		.raddr(head_q),
		.rdata(ring_rdata)
	);

	fbpa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(offset),
		.divisor (bs_eff),
		.done    (div_done),
		.result  (div_res)
	);

	always_ff @(posedge clk) begin
		vld_rd_q <= valid_q[head_q];
		if (state_q == S_READ) begin
			idx_q <= rd_idx;
		end
		prod_q <= PROD_W'(idx_q) * PROD_W'(bs_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			base_q   <= '0;
			size_q   <= SIZE_W'(64);
			count_q  <= CNT_W'(MAX_BLOCKS);
			enable_q <= 1'b0;
			head_q   <= '0;
			free_q   <= CNT_W'(MAX_BLOCKS);
			valid_q  <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_reg)
					REG_BASE_ADDRESS: base_q <= cfg_data[ADDR_W-1:0];
					REG_BLOCK_SIZE:   size_q <= cfg_data[SIZE_W-1:0];
					REG_BLOCK_COUNT: begin
						count_q <= cfg_data[CNT_W-1:0];
						valid_q <= '0;
						head_q  <= '0;
						if (cfg_data[CNT_W-1:0] == '0) begin
							free_q <= CNT_W'(1);
						end else if (cfg_data[CNT_W-1:0] > CNT_W'(MAX_BLOCKS)) begin
							free_q <= CNT_W'(MAX_BLOCKS);
						end else begin
							free_q <= cfg_data[CNT_W-1:0];
						end
					end
					REG_POOL_ENABLED: enable_q <= cfg_data[0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						result_q.block_address <= '0;
						result_q.slot_idx      <= '0;
						result_q.free_left     <= free_q;
						if (!enable_q) begin
							result_q.status <= ST_DISABLED;
							done_q          <= 1'b1;
						end else if (request.operation == OP_FREE) begin
							state_q <= S_DIV;
						end else if (too_large) begin
							result_q.status <= ST_TOO_LARGE;
							done_q          <= 1'b1;
						end else if (free_q == '0) begin
							result_q.status <= ST_POOL_EMPTY;
							done_q          <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					head_q  <= head_next;
					free_q  <= free_q - CNT_W'(1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					result_q.status        <= ST_OK;
					result_q.block_address <= base_q + ADDR_W'(prod_q);
					result_q.slot_idx      <= idx_q;
					result_q.free_left     <= free_q;
					done_q                 <= 1'b1;
					state_q                <= S_IDLE;
				end
				S_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						result_q.block_address <= '0;
						if (misaligned) begin
							result_q.status    <= ST_MISALIGNED;
							result_q.slot_idx  <= '0;
							result_q.free_left <= free_q;
						end else if (out_of_range) begin
							result_q.status    <= ST_OUT_OF_RANGE;
							result_q.slot_idx  <= '0;
							result_q.free_left <= free_q;
						end else if (ring_full) begin
							result_q.status    <= ST_RING_FULL;
							result_q.slot_idx  <= div_res.quotient[IDX_W-1:0];
							result_q.free_left <= free_q;
						end else begin
							result_q.status    <= ST_OK;
							result_q.slot_idx  <= div_res.quotient[IDX_W-1:0];
							result_q.free_left <= free_q + CNT_W'(1);
							free_q             <= free_q + CNT_W'(1);
							valid_q[pos]       <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

[src/fbpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[src/fbpa_div.sv]
// Restoring divider, one quotient bit per cycle, for address offset by block size.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [fbpa_pkg::ADDR_W-1:0] dividend,
	input  wire logic [fbpa_pkg::SIZE_W-1:0] divisor,
	output logic                           done,
	output fbpa_pkg::div_result_t          result
);
	import fbpa_pkg::*;

	localparam int STEP_W = $clog2(ADDR_W);

	logic [SIZE_W-1:0] rem_q;
	logic [ADDR_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;

	logic [SIZE_W:0]   trial;
	logic              fits;
	logic [SIZE_W:0]   diff;

	// Each step brings down the next dividend bit and subtracts if it fits.
	assign trial = {rem_q, quo_q[ADDR_W-1]};
	assign fits  = (trial >= {1'b0, divisor});
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(ADDR_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			quo_q <= {quo_q[ADDR_W-2:0], fits};
		end
	end

	assign done             = done_q;
	assign result.quotient  = quo_q;
	assign result.remainder = rem_q;

endmodule
`default_nettype wire

[src/fbpa_checker.sv]
// Port-level checks of the allocator and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic                       done,
	input wire fbpa_pkg::response_t        result
);
	import fbpa_pkg::*;

	// A result beat always closes the item, so the block is free again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done strobe while busy");

	// An accepted item either starts work or answers at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither busy nor answered");

	// Only a successful allocate carries an address.
	a_addr_zero_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.block_address == '0))
		else $error("rejected item carries an address");

	// The free count never exceeds the pool size.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.free_left <= CNT_W'(MAX_BLOCKS)))
		else $error("free count above pool size");

	// No result beat without an item in flight or just accepted.
	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !(start && !busy)) |=> !done)
		else $error("result beat with no item");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
`default_nettype wire
